>>> sv/candidate_score_sorter_macros.svh
// Assertion macros for the candidate score sorter.
`ifndef CANDIDATE_SCORE_SORTER_MACROS_SVH
`define CANDIDATE_SCORE_SORTER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while in reset
`define CSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSS_ASSERT_NOW(lbl, ante, cons, msg)
`define CSS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/csort_pkg.sv
package csort_pkg;

	localparam int MAX_CANDIDATES_DEF = 16;
	localparam int SCORE_W = 16;
	localparam int TAG_W = 8;
	localparam int TOTAL_W = 5;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   word_tag;
		logic               last_in_query;
		logic               empty_query;
	} in_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] sorted_score;
		logic [TAG_W-1:0]   sorted_tag;
		logic [TOTAL_W-1:0] candidate_total;
		logic               dropped;
		logic               end_of_list;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic ins;    // place the item in the chain
		logic flush;  // empty query: drop held list, give the zero result
		logic pop;    // shift the head out as a result
	} csort_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_pop;  // head is the only valid entry left
	} csort_stat_t;

endpackage

>>> sv/csort_ctrl.sv
module csort_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  csort_pkg::in_item_t    item,
	input  csort_pkg::csort_stat_t stat,
	output csort_pkg::csort_cmd_t  cmd,
	output logic                   busy
);
	import csort_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.empty_query) begin
						cmd.flush = 1'b1;
					end else begin
						cmd.ins = 1'b1;
						if (item.last_in_query) begin
							state_d = ST_EMIT;
						end
					end
				end
			end
			ST_EMIT: begin
				cmd.pop = 1'b1;
				if (stat.last_pop) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_EMIT);

endmodule

>>> sv/csort_dp.sv
module csort_dp #(
	parameter int MaxCand = csort_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  csort_pkg::in_item_t    item,
	input  csort_pkg::csort_cmd_t  cmd,
	output csort_pkg::csort_stat_t stat,
	output csort_pkg::result_t     result,
	output logic                   strobe
);
	import csort_pkg::*;

	localparam int CntW = $clog2(MaxCand + 1);

	// insertion chain, entry 0 holds the best score
	logic [SCORE_W-1:0] sc_q [MaxCand];
	logic [TAG_W-1:0]   tg_q [MaxCand];
	logic [MaxCand-1:0] vld_q;
	logic [MaxCand-1:0] vld_sh;
	logic [MaxCand-1:0] ge;
	logic [CntW-1:0]    cnt_q;
	logic               ovf_q;
	logic               full;
	logic               ins_ok;
	result_t            res_q;
	logic               strobe_q;

	assign full   = vld_q[MaxCand-1];
	assign ins_ok = cmd.ins && !full;
	assign vld_sh = vld_q >> 1;
	assign stat.last_pop = !vld_sh[0];

	for (genvar i = 0; i < MaxCand; i++) begin : g_cell
		logic               prev_ge;
		logic               prev_vld;
		logic [SCORE_W-1:0] prev_sc;
		logic [TAG_W-1:0]   prev_tg;
		logic [SCORE_W-1:0] next_sc;
		logic [TAG_W-1:0]   next_tg;
		logic               next_vld;
		logic               here;

		// ties keep arrival order: an equal score stays ahead of the new one
		assign ge[i] = vld_q[i] && (sc_q[i] >= item.score);

		if (i == 0) begin : g_head
			assign prev_ge  = 1'b1;
			assign prev_vld = 1'b1;
			assign prev_sc  = item.score;
			assign prev_tg  = item.word_tag;
		end else begin : g_body
			assign prev_ge  = ge[i-1];
			assign prev_vld = vld_q[i-1];
			assign prev_sc  = sc_q[i-1];
			assign prev_tg  = tg_q[i-1];
		end

		if (i == MaxCand - 1) begin : g_tail
			assign next_sc  = sc_q[i];
			assign next_tg  = tg_q[i];
			assign next_vld = 1'b0;
		end else begin : g_mid
			assign next_sc  = sc_q[i+1];
			assign next_tg  = tg_q[i+1];
			assign next_vld = vld_q[i+1];
		end

		assign here = ins_ok && !ge[i];

		always_ff @(posedge clk) begin
			if (here) begin
				sc_q[i] <= prev_ge ? item.score : prev_sc;
				tg_q[i] <= prev_ge ? item.word_tag : prev_tg;
			end else if (cmd.pop) begin
				sc_q[i] <= next_sc;
				tg_q[i] <= next_tg;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (cmd.flush) begin
				vld_q[i] <= 1'b0;
			end else if (here) begin
				vld_q[i] <= vld_q[i] | prev_vld;
			end else if (cmd.pop) begin
				vld_q[i] <= next_vld;
			end
		end
	end

	// count stays put while the list drains so every result carries the total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.flush || cmd.pop;
			if (cmd.flush || (cmd.pop && stat.last_pop)) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cmd.ins) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			res_q.sorted_score    <= '0;
			res_q.sorted_tag      <= '0;
			res_q.candidate_total <= '0;
			res_q.dropped         <= 1'b0;
			res_q.end_of_list     <= 1'b1;
		end else if (cmd.pop) begin
			res_q.sorted_score    <= sc_q[0];
			res_q.sorted_tag      <= tg_q[0];
			res_q.candidate_total <= TOTAL_W'(cnt_q);
			res_q.dropped         <= ovf_q;
			res_q.end_of_list     <= stat.last_pop;
		end
	end

	assign result = res_q;
	assign strobe = strobe_q;

endmodule

>>> sv/candidate_score_sorter.sv
// Candidate items enter one per cycle while busy is low; each is placed in the sorted chain in the cycle it is taken.
// An item marked last starts the drain: busy rises, and the results are registered from the chain head,
// one per cycle, n results for n held candidates; busy stays high until the last of them is popped.
// An empty-query item gives its single result in the next cycle and does not raise busy.
// The drain shifts the MAX_CANDIDATES-cell chain by one entry a cycle, which sets that rate.
// Reset (arst_n low) empties the chain and drops any query in progress; no result follows.
`include "candidate_score_sorter_macros.svh"

module candidate_score_sorter #(
	parameter int MAX_CANDIDATES = csort_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  csort_pkg::in_item_t item,
	output logic                busy,
	output csort_pkg::result_t  result,
	output logic                result_strobe
);
	import csort_pkg::*;

	csort_cmd_t  cmd;
	csort_stat_t stat;

	csort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	csort_dp #(
		.MaxCand (MAX_CANDIDATES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.strobe (result_strobe)
	);

	`CSS_ASSERT_NXT(a_empty_result, start && !busy && item.empty_query, result_strobe && result.end_of_list && (result.candidate_total == '0), "empty query must give one closing result")
	`CSS_ASSERT_NXT(a_last_drains, start && !busy && !item.empty_query && item.last_in_query, busy, "last item must start the drain")
	`CSS_ASSERT_NXT(a_drain_order, result_strobe && !result.end_of_list, result_strobe && (result.sorted_score <= $past(result.sorted_score)), "results must be back to back and descending")

endmodule

>>> dv/candidate_score_sorter_tb.sv
`timescale 1ns / 100ps

module candidate_score_sorter_tb;
	import csort_pkg::*;

	localparam int MAX_HELD = MAX_CANDIDATES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_ITEMS = 230;

	// Tracks the sorted chain of the current query and the ranked results still owed.
	class candidate_rank_board;
		logic [SCORE_W-1:0] chain_score [MAX_HELD];
		logic [TAG_W-1:0]   chain_tag [MAX_HELD];
		int                 chain_fill;
		bit                 chain_overflow;
		result_t            pending_ranks [$];
		int                 mismatches;

		function new();
			chain_fill = 0;
			chain_overflow = 0;
			mismatches = 0;
		endfunction

		function void note_candidate(in_item_t it);
			result_t r;
			int pos;
			int k;
			if (it.empty_query) begin
				r = '0;
				r.end_of_list = 1'b1;
				pending_ranks.push_back(r);
				chain_fill = 0;
				chain_overflow = 0;
				return;
			end
			if (chain_fill >= MAX_HELD) begin
				chain_overflow = 1;
			end else begin
				// ties go behind the earlier arrivals
				pos = 0;
				while (pos < chain_fill && chain_score[pos] >= it.score)
					pos++;
				for (k = chain_fill; k > pos; k--) begin
					chain_score[k] = chain_score[k-1];
					chain_tag[k] = chain_tag[k-1];
				end
				chain_score[pos] = it.score;
				chain_tag[pos] = it.word_tag;
				chain_fill++;
			end
			if (!it.last_in_query)
				return;
			for (k = 0; k < chain_fill; k++) begin
				r.sorted_score = chain_score[k];
				r.sorted_tag = chain_tag[k];
				r.candidate_total = chain_fill[TOTAL_W-1:0];
				r.dropped = chain_overflow;
				r.end_of_list = (k + 1 == chain_fill);
				pending_ranks.push_back(r);
			end
			chain_fill = 0;
			chain_overflow = 0;
		endfunction

		function void check_ranked(result_t got);
			result_t want;
			bit bad;
			if (pending_ranks.size() == 0) begin
				$display("%0t: result with nothing expected: score %h tag %h total %0d drop %b eol %b",
					$time, got.sorted_score, got.sorted_tag, got.candidate_total,
					got.dropped, got.end_of_list);
				mismatches++;
				return;
			end
			want = pending_ranks.pop_front();
			bad = 0;
			if (got.sorted_score !== want.sorted_score) bad = 1;
			if (got.sorted_tag !== want.sorted_tag) bad = 1;
			if (got.candidate_total !== want.candidate_total) bad = 1;
			if (got.dropped !== want.dropped) bad = 1;
			if (got.end_of_list !== want.end_of_list) bad = 1;
			if (bad) begin
				$display("%0t: mismatch expected score %h tag %h total %0d drop %b eol %b",
					$time, want.sorted_score, want.sorted_tag, want.candidate_total,
					want.dropped, want.end_of_list);
				$display("%0t:          actual   score %h tag %h total %0d drop %b eol %b",
					$time, got.sorted_score, got.sorted_tag, got.candidate_total,
					got.dropped, got.end_of_list);
				mismatches++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	in_item_t item;
	logic     busy;
	result_t  result;
	logic     result_strobe;

	candidate_rank_board ranks;
	int cycle_count;
	int items_sent;

	candidate_score_sorter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result       (result),
		.result_strobe(result_strobe)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		cycle_count = 0;
		wait (cycle_count >= CYCLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			ranks.check_ranked(result);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// bias toward extremes and a narrow range so ties come up often
	function automatic logic [SCORE_W-1:0] pick_score();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return '0;
		if (r < 24)
			return '1;
		if (r < 50)
			return SCORE_W'($urandom_range(0, 3));
		return SCORE_W'($urandom_range(0, 65535));
	endfunction

	function automatic in_item_t make_item(logic [SCORE_W-1:0] s, logic [TAG_W-1:0] t,
		logic last, logic empty);
		in_item_t it;
		it.score = s;
		it.word_tag = t;
		it.last_in_query = last;
		it.empty_query = empty;
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic send_item(in_item_t it, bit allow_gap);
		int gap;
		gap = allow_gap ? pick_gap() : 0;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		item = it;
		do
			@(posedge clk);
		while (busy);
		ranks.note_candidate(it);
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_query(int len, bit allow_gap);
		int k;
		for (k = 0; k < len; k++)
			send_item(make_item(pick_score(), TAG_W'($urandom_range(0, 255)), k == len - 1,
				1'b0), allow_gap);
	endtask

	task automatic wait_drained();
		while (ranks.pending_ranks.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int k;
		int r;
		int qnum;
		ranks = new();
		items_sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty query, extreme single candidate, ties
		send_item(make_item(16'h0000, 8'h00, 1'b0, 1'b1), 0);
		send_item(make_item(16'hffff, 8'hff, 1'b1, 1'b0), 0);
		send_item(make_item(16'h0005, 8'h01, 1'b0, 1'b0), 0);
		send_item(make_item(16'h0005, 8'h02, 1'b0, 1'b0), 0);
		send_item(make_item(16'h0005, 8'h03, 1'b1, 1'b0), 0);
		// store full, the extra last item is dropped but the list still comes out
		for (k = 0; k < MAX_HELD + 1; k++)
			send_item(make_item(k[0] ? 16'hffff : 16'(k), 8'(k + 8'h80), k == MAX_HELD,
				1'b0), 0);
		// unfinished query then an empty item with junk in the other fields
		send_item(make_item(16'h1234, 8'h55, 1'b0, 1'b0), 0);
		send_item(make_item(16'h0000, 8'haa, 1'b0, 1'b0), 0);
		send_item(make_item(16'hffff, 8'hff, 1'b1, 1'b1), 0);

		qnum = 0;
		while (items_sent < NUM_ITEMS) begin
			qnum++;
			if (qnum == 12)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < 8) begin
				send_item(make_item(SCORE_W'($urandom_range(0, 65535)),
					TAG_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1), 1);
			end else if (r < 90) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					send_query($urandom_range(1, 5), 1);
				else if (r < 90)
					send_query($urandom_range(6, MAX_HELD - 1), 1);
				else
					send_query($urandom_range(MAX_HELD, MAX_HELD + 4), 1);
			end else begin
				// query cut short by an empty item
				r = $urandom_range(1, MAX_HELD + 2);
				for (k = 0; k < r; k++)
					send_item(make_item(pick_score(), TAG_W'($urandom_range(0, 255)), 1'b0,
						1'b0), 1);
				send_item(make_item(SCORE_W'($urandom_range(0, 65535)),
					TAG_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1), 1);
			end
		end
		start = 1'b0;

		wait_drained();
		repeat (30) @(posedge clk);
		if (ranks.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
